### hdl/indexed_sequence_store_top_macros.svh
`ifndef INDEXED_SEQUENCE_STORE_TOP_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_TOP_MACROS_SVH

// property checked at every clock edge outside reset
`define ISS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence checked in the cycle after the trigger
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/iss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

  localparam int KIND_W   = 2;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int DATA_W_O = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

### hdl/iss_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface iss_req_if;
  import iss_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink (input valid, input kind, input position, input value, output ready);
endinterface

`default_nettype wire

### hdl/iss_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface iss_rsp_if;
  import iss_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W_O-1:0] data;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output data, output status, output count, input ready);
  modport sink (input valid, input data, input status, input count, output ready);
endinterface

`default_nettype wire

### hdl/indexed_sequence_store_top.sv
// append: accept, then S_DONE loads the result word; read: accept, S_RDWAIT, then S_DONE
// remove at position p with n elements held: S_RMDATA, then S_SHIFT moves n - 1 - p entries, one entry moved per cycle
// through the single write port of the element memory; one request in flight at a time
// a new request is taken while the previous result word still waits on the output register
// synchronous active-high reset empties the store; element memory itself is not cleared
`timescale 1ns / 1ps
`default_nettype none

module indexed_sequence_store_top #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  iss_req_if.sink   req,
  iss_rsp_if.source rsp
);
  import iss_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  iss_ctrl #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  iss_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

### hdl/iss_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module iss_mem #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/iss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_sequence_store_top_macros.svh"

module iss_ctrl #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  iss_req_if.sink                req,
  iss_rsp_if.source              rsp,
  output logic                   mem_we,
  output logic      [AW-1:0]     mem_waddr,
  output logic      [DATA_W-1:0] mem_wdata,
  output logic      [AW-1:0]     mem_raddr,
  input  wire logic [DATA_W-1:0] mem_rdata
);
  import iss_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > POS_W) ? LW : POS_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RDWAIT = 5'b00010,
    S_RMDATA = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t              state;
  logic [LW-1:0]       len;
  logic [AW-1:0]       idx;
  logic [DATA_W-1:0]   res_data;
  logic [STATUS_W-1:0] res_status;
  logic                out_valid;
  logic [DATA_W_O-1:0] out_data;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;

  logic          acc;
  logic          full;
  logic          in_range;
  logic [CW-1:0] pos_c;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign pos_c     = CW'(req.position);
  assign in_range  = pos_c < CW'(len);
  assign full      = (len == LW'(DEPTH));

  assign rsp.valid  = out_valid;
  assign rsp.data   = out_data;
  assign rsp.status = out_status;
  assign rsp.count  = out_count;

  always_comb begin
    case (state)
      S_IDLE:   mem_raddr = AW'(pos_c);
      S_RMDATA: mem_raddr = idx + AW'(1);
      S_SHIFT:  mem_raddr = idx + AW'(2);
      default:  mem_raddr = idx;
    endcase
  end

  assign mem_we    = (acc && req.kind == KIND_APPEND && !full) || (state == S_SHIFT);
  assign mem_waddr = (state == S_SHIFT) ? idx : AW'(len);
  assign mem_wdata = (state == S_SHIFT) ? mem_rdata : DATA_W'(req.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            res_data   <= '0;
            res_status <= ST_OK;
            idx        <= AW'(pos_c);
            state      <= S_DONE;
            case (req.kind)
              KIND_APPEND: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  len <= len + LW'(1);
                end
              end
              KIND_READ: begin
                if (in_range) begin
                  state <= S_RDWAIT;
                end else begin
                  res_status <= ST_RANGE;
                end
              end
              KIND_REMOVE: begin
                if (in_range) begin
                  state <= S_RMDATA;
                end else begin
                  res_status <= ST_RANGE;
                end
              end
              default: begin
                res_status <= ST_OK;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          res_data <= mem_rdata;
          state    <= S_DONE;
        end
        S_RMDATA: begin
          res_data <= mem_rdata;
          if (LW'(idx) + LW'(1) < len) begin
            state <= S_SHIFT;
          end else begin
            len   <= len - LW'(1);
            state <= S_DONE;
          end
        end
        S_SHIFT: begin
          idx <= idx + AW'(1);
          if (!(LW'(idx) + LW'(2) < len)) begin
            len   <= len - LW'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_data   <= DATA_W_O'(res_data);
            out_status <= res_status;
            out_count  <= COUNT_W'(len);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ISS_ASSERT(a_len_bound, len <= LW'(DEPTH), "element count above depth")
  `ISS_ASSERT(a_write_in_bounds, !mem_we || (LW'(mem_waddr) <= len), "write past the tail")
  `ISS_ASSERT(a_shift_source, (state != S_SHIFT) || (LW'(idx) + LW'(1) < len), "shift source past the tail")
  `ISS_ASSERT_NEXT(a_append_grows, acc && req.kind == KIND_APPEND && !full, len == $past(len) + LW'(1), "append did not grow the count")

endmodule

`default_nettype wire
